FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is released.
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: hw/rtl/aes128_pkg.sv
`default_nettype none
package aes128_pkg;

    localparam int KEY_W     = 64;
    localparam int CFG_IDX_W = 1;
    localparam int ROUNDS    = 10;
    localparam int ROUND_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_plain;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_cipher;

    localparam logic [7:0] SBOX_TAB [0:255] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX_TAB[b];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] round);
        logic [7:0] v;
        case (round)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1B;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aes128_key_step.sv
`default_nettype none
// Derives the next round key (four words) from the current one.
module aes128_key_step (
    input  wire logic [127:0] i_rkey,
    input  wire logic [7:0]   i_rcon,
    output logic [127:0]      o_rkey
);
    import aes128_pkg::*;

    logic [31:0] w0, w1, w2, w3, rot, t, n0, n1, n2, n3;

    always_comb begin
        w0  = i_rkey[127:96];
        w1  = i_rkey[95:64];
        w2  = i_rkey[63:32];
        w3  = i_rkey[31:0];
        rot = {w3[23:0], w3[31:24]};
        t   = {sbox(rot[31:24]) ^ i_rcon, sbox(rot[23:16]), sbox(rot[15:8]), sbox(rot[7:0])};
        n0  = w0 ^ t;
        n1  = w1 ^ n0;
        n2  = w2 ^ n1;
        n3  = w3 ^ n2;
        o_rkey = {n0, n1, n2, n3};
    end

endmodule
`default_nettype wire

FILE: hw/rtl/aes128_round.sv
`default_nettype none
// One cipher round: SubBytes, ShiftRows, MixColumns unless this is the
// last round, then AddRoundKey.
module aes128_round (
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_rkey,
    input  wire logic         i_last,
    output logic [127:0]      o_state
);
    import aes128_pkg::*;

    logic [7:0] a   [16];
    logic [7:0] t   [16];
    logic [7:0] m   [16];
    logic [7:0] all [4];

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            a[k] = i_state[8*(15-k) +: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = sbox(a[4*((c+r) & 3)+r]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            all[c]   = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c]   = t[4*c]   ^ all[c] ^ xtime(t[4*c]   ^ t[4*c+1]);
            m[4*c+1] = t[4*c+1] ^ all[c] ^ xtime(t[4*c+1] ^ t[4*c+2]);
            m[4*c+2] = t[4*c+2] ^ all[c] ^ xtime(t[4*c+2] ^ t[4*c+3]);
            m[4*c+3] = t[4*c+3] ^ all[c] ^ xtime(t[4*c+3] ^ t[4*c]);
        end
        for (int k = 0; k < 16; k++) begin
            o_state[8*(15-k) +: 8] = (i_last ? t[k] : m[k]) ^ i_rkey[8*(15-k) +: 8];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/aes128_block_encrypt_core.sv
`default_nettype none
// AES-128 block encryption core.
//
// Plaintext requests arrive on the input channel (i_in_valid / o_in_ready,
// payload i_in_data) and ciphertext requests leave on the output channel
// (o_out_valid / i_out_ready, payload o_out_data). The 128-bit key is held
// in two registers written through the plain write port (i_cfg_we,
// i_cfg_index, i_cfg_data); index 0 is the high half, index 1 the low half.
//
// One round unit and one key-step unit are reused for all ten rounds, and
// round keys are derived on the fly from the key registers, so no key
// schedule memory is kept. The initial key addition happens in the accept
// cycle, then one round runs per cycle, the last one only once the output
// register is free. A new plaintext is taken only after the previous one
// has left the round loop, since the round unit is shared.
//
// Reset clears the key registers to zero and empties the output register.
// A finished ciphertext waits in the output register while the next
// plaintext is being processed; if it is still not taken when the next
// one completes, the last round holds until the receiver accepts.
module aes128_block_encrypt_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire aes128_pkg::t_plain                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output aes128_pkg::t_cipher                    o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [aes128_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [aes128_pkg::KEY_W-1:0]      i_cfg_data
);
    import aes128_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_fsm;

    t_fsm               r_fsm;
    logic [KEY_W-1:0]   r_key_high;
    logic [KEY_W-1:0]   r_key_low;
    logic [127:0]       r_block;
    logic [127:0]       r_rkey;
    logic [ROUND_W-1:0] r_round;
    logic               r_out_valid;
    t_cipher            r_out_data;

    logic [127:0] n_rkey;
    logic [127:0] n_block;
    logic         last;
    logic         out_free;

    assign last     = (r_round == ROUND_W'(ROUNDS));
    assign out_free = !r_out_valid || i_out_ready;

    aes128_key_step u_key_step (
        .i_rkey (r_rkey),
        .i_rcon (rcon(r_round)),
        .o_rkey (n_rkey)
    );

    aes128_round u_round (
        .i_state (r_block),
        .i_rkey  (n_rkey),
        .i_last  (last),
        .o_state (n_block)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_round     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    default:      ;
                endcase
            end

            // A new result may land in the same cycle the old one is taken.
            if (r_fsm == S_RUN && last && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_fsm)
                S_IDLE: begin
                    if (i_in_valid) begin
                        // Initial AddRoundKey with the cipher key itself.
                        r_block <= i_in_data ^ {r_key_high, r_key_low};
                        r_rkey  <= {r_key_high, r_key_low};
                        r_round <= ROUND_W'(1);
                        r_fsm   <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!last) begin
                        r_block <= n_block;
                        r_rkey  <= n_rkey;
                        r_round <= r_round + ROUND_W'(1);
                    end else if (out_free) begin
                        // Final round result goes straight to the output.
                        r_out_data  <= n_block;
                        r_fsm       <= S_IDLE;
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_fsm == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

FILE: hw/rtl/aes128_checker.sv
`default_nettype none
`include "assert_macros.svh"
// Port-level checks for the encryption core.
module aes128_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire aes128_pkg::t_cipher o_out_data
);
    import aes128_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // Reset empties the output register.
    `ASSERT_CLK(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // An accepted plaintext keeps the core busy for the following cycle.
    `ASSERT_RUN(a_busy, i_clk, i_rst_n, in_acc |=> !o_in_ready, "ready right after accept")

    // A result cannot appear the cycle after a plaintext was taken.
    `ASSERT_RUN(a_no_early, i_clk, i_rst_n, in_acc |=> !$rose(o_out_valid), "result too early")

    // A stalled ciphertext stays and holds its value.
    `ASSERT_RUN(a_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)), "output dropped")

endmodule

bind aes128_block_encrypt_core aes128_checker u_aes128_checker (.*);
`default_nettype wire

FILE: tb/aes128_block_encrypt_core_tb.sv
`timescale 1ns / 1ps

// Testbench for the AES-128 block encryption core.
//
// A driver and a monitor, both clocked always blocks, talk to the core over
// its two valid/ready channels. The main initial block fills a queue of
// pending plaintext requests, and the driver feeds them to the core. The
// driver predicts the ciphertext of every request at acceptance and files it
// in a queue of expected ciphertexts. The monitor checks every ciphertext
// request that the core hands out against the oldest entry in that queue.
// The key registers are only rewritten while nothing is in flight.
module aes128_block_encrypt_core_tb;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  o_in_ready;
    aes128_pkg::t_plain                    in_data = '0;
    logic                                  o_out_valid;
    logic                                  out_ready = 1'b0;
    aes128_pkg::t_cipher                   o_out_data;
    logic                                  cfg_we = 1'b0;
    logic [aes128_pkg::CFG_IDX_W-1:0]      cfg_index = aes128_pkg::CFG_KEY_HIGH;
    logic [aes128_pkg::KEY_W-1:0]          cfg_data = '0;

    // Plaintext requests waiting for the driver, and ciphertexts that the
    // core still owes us, oldest first.
    aes128_pkg::t_plain  plain_q[$];
    aes128_pkg::t_cipher cipher_expect_q[$];

    // The predictor's own copy of the key and of the expanded key schedule.
    logic [63:0] key_high_copy;
    logic [63:0] key_low_copy;
    logic [31:0] sched_words [44];
    logic [7:0]  sbox_lut [256];

    // Percentage of cycles in which the sender holds back a request and in
    // which the receiver refuses a result.
    int unsigned src_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    int          mismatch_count = 0;

    aes128_block_encrypt_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // GF(2^8) arithmetic modulo the AES polynomial x^8 + x^4 + x^3 + x + 1.
    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i])
                p = p ^ a;
            a = gf_double(a);
        end
        return p;
    endfunction

    // The S-box is derived rather than copied: the multiplicative inverse
    // (b^254, which maps zero to zero) followed by the affine transform.
    task automatic build_sbox();
        logic [7:0] inv;
        for (int b = 0; b < 256; b++) begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++)
                inv = gf_mul(inv, b[7:0]);
            sbox_lut[b] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endtask

    // Rebuilds all 44 round-key words from the current key copy.
    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        sched_words[0] = key_high_copy[63:32];
        sched_words[1] = key_high_copy[31:0];
        sched_words[2] = key_low_copy[63:32];
        sched_words[3] = key_low_copy[31:0];
        for (int i = 4; i < 44; i++) begin
            t = sched_words[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sbox_lut[t[31:24]] ^ rc, sbox_lut[t[23:16]],
                     sbox_lut[t[15:8]], sbox_lut[t[7:0]]};
                rc = gf_double(rc);
            end
            sched_words[i] = sched_words[i-4] ^ t;
        end
    endfunction

    // Full AES-128 encryption of one block under the current schedule. The
    // state is kept column by column: byte 4c+r is row r of column c.
    function automatic aes128_pkg::t_cipher encrypt_block(input aes128_pkg::t_plain pt);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [31:0] w;
        aes128_pkg::t_cipher ct;
        for (int i = 0; i < 8; i++) begin
            st[i]   = pt.plain_high[63-8*i -: 8];
            st[i+8] = pt.plain_low[63-8*i -: 8];
        end
        for (int rnd = 0; rnd <= 10; rnd++) begin
            if (rnd > 0) begin
                // SubBytes and ShiftRows together: row r moves left by r.
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[4*c+r] = sbox_lut[st[4*((c+r)%4)+r]];
                st = tmp;
                // The last round skips MixColumns.
                if (rnd < 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = st[4*c];
                        a1 = st[4*c+1];
                        a2 = st[4*c+2];
                        a3 = st[4*c+3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        st[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                        st[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                        st[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                        st[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                w = sched_words[4*rnd+c];
                for (int k = 0; k < 4; k++)
                    st[4*c+k] = st[4*c+k] ^ w[31-8*k -: 8];
            end
        end
        for (int i = 0; i < 8; i++) begin
            ct.cipher_high[63-8*i -: 8] = st[i];
            ct.cipher_low[63-8*i -: 8]  = st[i+8];
        end
        return ct;
    endfunction

    // Driver. The ciphertext of a request is predicted at the edge where the
    // core accepts it. A new request is only presented once the previous one
    // is gone, so valid never drops while a request is waiting.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                cipher_expect_q.push_back(encrypt_block(in_data));
            if (!in_valid || o_in_ready) begin
                if (plain_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= plain_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_cipher(input aes128_pkg::t_cipher got);
        aes128_pkg::t_cipher want;
        if (cipher_expect_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected ciphertext %h %h with no request pending",
                         got.cipher_high, got.cipher_low);
        end else begin
            want = cipher_expect_q.pop_front();
            if (got.cipher_high !== want.cipher_high
                    || got.cipher_low !== want.cipher_low) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ciphertext mismatch: expected %h %h, got %h %h",
                             want.cipher_high, want.cipher_low,
                             got.cipher_high, got.cipher_low);
            end
        end
    endtask

    // Monitor. Outputs are sampled at the edge, before the core updates them,
    // and ready is redrawn every cycle from the current stall rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready)
                check_cipher(o_out_data);
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Waits, sampling at the falling edge, until no request is queued, none
    // is being offered and no ciphertext is still owed. The caller is left
    // at a falling edge.
    task automatic wait_drained();
        @(negedge i_clk);
        while (plain_q.size() != 0 || in_valid || cipher_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    // One register write, mirrored into the predictor once the core has
    // taken it. Ends at a falling edge so that requests can be queued
    // without racing the driver.
    task automatic write_key(input logic [aes128_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == aes128_pkg::CFG_KEY_HIGH)
            key_high_copy = val;
        else
            key_low_copy = val;
        expand_schedule();
        @(negedge i_clk);
    endtask

    task automatic queue_plain(input logic [63:0] hi, input logic [63:0] lo);
        aes128_pkg::t_plain pt;
        pt.plain_high = hi;
        pt.plain_low  = lo;
        plain_q.push_back(pt);
    endtask

    // Mostly random halves, with the all-zero and all-one extremes mixed in.
    function automatic logic [63:0] random_half();
        logic [63:0] v;
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // A new key, sometimes with only one half rewritten so that a partly
    // updated key gets used as it stands.
    task automatic load_random_key();
        case ($urandom_range(3))
            0: write_key(aes128_pkg::CFG_KEY_HIGH, random_half());
            1: write_key(aes128_pkg::CFG_KEY_LOW, random_half());
            default: begin
                write_key(aes128_pkg::CFG_KEY_HIGH, random_half());
                write_key(aes128_pkg::CFG_KEY_LOW, random_half());
            end
        endcase
    endtask

    initial begin
        build_sbox();
        key_high_copy = '0;
        key_low_copy  = '0;
        expand_schedule();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, no idling on either side. First, blocks encrypted
        // under the all-zero key that reset leaves behind.
        queue_plain(64'h0, 64'h0);
        queue_plain('1, '1);
        queue_plain(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_plain(64'h8080_8080_8080_8080, 64'h0101_0101_0101_0101);
        wait_drained();

        // Only the high half of the key rewritten: the half-updated key is
        // used as it is.
        write_key(aes128_pkg::CFG_KEY_HIGH, 64'h0001_0203_0405_0607);
        queue_plain(64'h0, 64'h0);
        queue_plain(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
        wait_drained();

        // Now the full standard example key.
        write_key(aes128_pkg::CFG_KEY_LOW, 64'h0809_0A0B_0C0D_0E0F);
        queue_plain(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
        queue_plain(64'h0, 64'h0);
        queue_plain('1, '1);
        wait_drained();

        // The all-one key.
        write_key(aes128_pkg::CFG_KEY_HIGH, '1);
        write_key(aes128_pkg::CFG_KEY_LOW, '1);
        queue_plain(64'h0, 64'h0);
        queue_plain('1, '1);
        queue_plain(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        wait_drained();

        write_key(aes128_pkg::CFG_KEY_HIGH, 64'h2B7E_1516_28AE_D2A6);
        write_key(aes128_pkg::CFG_KEY_LOW, 64'hABF7_1588_09CF_4F3C);
        queue_plain(64'h3243_F6A8_885A_308D, 64'h3131_98A2_E037_0734);
        queue_plain(64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE);
        wait_drained();

        // Back to the all-zero key by explicit writes.
        write_key(aes128_pkg::CFG_KEY_HIGH, '0);
        write_key(aes128_pkg::CFG_KEY_LOW, '0);
        queue_plain(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
        wait_drained();

        // Random part in four idling phases. Each phase runs three batches,
        // each under a fresh key; the sender waits for the core to drain
        // completely before every key change.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 76; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 76; end
                default: begin src_gap_pct = 17; sink_stall_pct = 17; end
            endcase
            for (int b = 0; b < 3; b++) begin
                wait_drained();
                load_random_key();
                for (int n = 0; n < 46; n++)
                    queue_plain(random_half(), random_half());
            end
        end

        wait_drained();
        // Nothing is owed any more; keep the clock running so that any stray
        // output can still show up at the monitor.
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("aes128_block_encrypt_core_tb: done, clean");
        else
            $display("aes128_block_encrypt_core_tb: done, errors");
        $finish;
    end

    // Watchdog: reports errors and ends the run if the main block has not finished.
    initial begin
        #(3_000_000);
        $display("aes128_block_encrypt_core_tb: done, errors");
        $finish;
    end

endmodule

FILE: aes128_block_encrypt_core.f
+incdir+hw/rtl
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_key_step.sv
hw/rtl/aes128_round.sv
hw/rtl/aes128_block_encrypt_core.sv
hw/rtl/aes128_checker.sv
tb/aes128_block_encrypt_core_tb.sv
